FILE: rtl/fsca_pkg.sv
// Shared types and constants for the fit-strategy chunk allocator.
package fsca_pkg;

  localparam int DATA_W    = 32;
  localparam int CFG_IDX_W = 2;
  localparam int STATUS_W  = 2;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_STRATEGY   = 2'd0,
    CFG_HEAP_START = 2'd1,
    CFG_HEAP_LIMIT = 2'd2
  } cfg_idx_e;

  typedef enum logic [1:0] {
    STRAT_FIRST = 2'd0,
    STRAT_BEST  = 2'd1,
    STRAT_WORST = 2'd2
  } strategy_e;

  typedef enum logic [STATUS_W-1:0] {
    ST_OK      = 2'd0,
    ST_NOHEAP  = 2'd1,
    ST_FULL    = 2'd2,
    ST_UNKNOWN = 2'd3
  } status_e;

  typedef enum logic [2:0] {
    S_IDLE,
    S_SCAN,
    S_A_DECIDE,
    S_A_SPLIT,
    S_A_HEAP1,
    S_A_HEAP2,
    S_A_HEAP3,
    S_F_UPDATE
  } state_e;

endpackage

FILE: rtl/fsca_ram.sv
// Generic single-write, single-read RAM with registered read data.
module fsca_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 16
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
    rdata_o <= mem[raddr_i];
  end

endmodule

FILE: rtl/fsca_addsub.sv
// Shared adder/subtractor; on subtract, carry out high means a >= b.
module fsca_addsub #(
  parameter int WIDTH = 32
) (
  input  logic [WIDTH-1:0] a_i,
  input  logic [WIDTH-1:0] b_i,
  input  logic             sub_i,
  output logic [WIDTH-1:0] sum_o,
  output logic             co_o
);

  logic [WIDTH:0] full;

  assign full  = {1'b0, a_i} + {1'b0, b_i ^ {WIDTH{sub_i}}} + (WIDTH + 1)'(sub_i);
  assign sum_o = full[WIDTH-1:0];
  assign co_o  = full[WIDTH];

endmodule

FILE: rtl/fit_strategy_chunk_allocator.sv
// Top level of the fit-strategy chunk allocator (free list with first/best/worst fit).
//
// Usage:
//   Configuration: cfg_we_i with cfg_idx_i selects strategy (0), heap_start (1) or
//   heap_limit (2); cfg_wdata_i is written at that edge. Writing heap_start also
//   loads the heap top. Write only while busy_o is low.
//   Requests: a word is taken at a rising edge with start_i high and busy_o low.
//   action_i = 0 allocates request_size_i bytes, action_i = 1 frees the chunk
//   that starts at block_address_i.
//   Results: result_valid_o pulses for one cycle with result_address_o and
//   status_o (0 ok, 1 out of heap, 2 table full, 3 unknown address). The
//   receiver cannot stall, so the result is lost if not sampled then.
// Request sequence:
//   Every request sweeps max(FREE_ENTRIES, USED_ENTRIES) table slots, one per
//   cycle through the registered read port of each table RAM, then drains the
//   check stage. Then an allocate from the free table passes S_A_DECIDE and
//   S_A_SPLIT, one that grows the heap S_A_DECIDE and S_A_HEAP1 to S_A_HEAP3, a
//   free S_F_UPDATE. The time from accept to result strobe is set by the table
//   sweep and by the single shared adder that does the size and address sums in turn.
// Reset: both tables empty, strategy first fit, heap top 0, limit all ones.
module fit_strategy_chunk_allocator #(
  parameter int FREE_ENTRIES = 16,
  parameter int USED_ENTRIES = 16,
  parameter int ADDR_BITS    = 32
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           cfg_we_i,
  input  logic [fsca_pkg::CFG_IDX_W-1:0] cfg_idx_i,
  input  logic [fsca_pkg::DATA_W-1:0]    cfg_wdata_i,
  input  logic                           start_i,
  output logic                           busy_o,
  input  logic                           action_i,
  input  logic [fsca_pkg::DATA_W-1:0]    request_size_i,
  input  logic [fsca_pkg::DATA_W-1:0]    block_address_i,
  output logic                           result_valid_o,
  output logic [fsca_pkg::DATA_W-1:0]    result_address_o,
  output logic [fsca_pkg::STATUS_W-1:0]  status_o
);

  import fsca_pkg::*;

  localparam int AB   = ADDR_BITS;
  localparam int FW   = $clog2(FREE_ENTRIES);
  localparam int UW   = $clog2(USED_ENTRIES);
  localparam int MAXE = (FREE_ENTRIES > USED_ENTRIES) ? FREE_ENTRIES : USED_ENTRIES;
  localparam int CW   = $clog2(MAXE + 1);

  typedef struct packed {
    logic [AB-1:0] start;
    logic [AB-1:0] size;
  } entry_t;

  // Sequencer and configuration
  state_e                state_q, state_d;
  logic [1:0]            strategy_q;
  logic [AB-1:0]         heap_top_q;
  logic [AB-1:0]         heap_limit_q;
  logic                  accept;

  // Latched request
  logic                  action_q;
  logic [AB-1:0]         req_q;
  logic [AB-1:0]         target_q;

  // Table valid bits
  logic [FREE_ENTRIES-1:0] free_valid_q;
  logic [USED_ENTRIES-1:0] used_valid_q;

  // Sweep pipeline: issue address, then check the registered read data
  logic [CW-1:0]         scan_q;
  logic                  chk_q;
  logic [CW-1:0]         chk_idx_q;
  logic                  chk_free, chk_used;
  logic [FW-1:0]         fidx;
  logic [UW-1:0]         uidx;
  logic                  f_ent_valid, u_ent_valid;
  logic                  take_pick;

  // Sweep findings
  logic                  pick_found_q;
  logic [FW-1:0]         pick_idx_q;
  entry_t                pick_q;
  logic                  uemp_found_q;
  logic [UW-1:0]         uemp_idx_q;
  logic                  femp_found_q;
  logic [FW-1:0]         femp_idx_q;
  logic                  hit_found_q;
  logic [UW-1:0]         hit_idx_q;
  entry_t                hit_q;

  // Update-phase scratch
  logic [AB-1:0]         rem_q;
  logic [AB-1:0]         room_q;
  logic                  top_ok_q;

  // Shared adder
  logic [AB-1:0]         alu_a, alu_b, alu_sum;
  logic                  alu_sub, alu_co;

  // Table RAM ports
  entry_t                fr_rd, ur_rd;
  logic                  fr_we, ur_we;
  logic [FW-1:0]         fr_waddr;
  logic [UW-1:0]         ur_waddr;
  entry_t                fr_wdata, ur_wdata;

  // Valid-bit and heap updates, result
  logic                  fv_set, fv_clr;
  logic [FW-1:0]         fv_idx;
  logic                  uv_set, uv_clr;
  logic [UW-1:0]         uv_idx;
  logic                  heap_we;
  logic                  done;
  status_e               done_status;
  logic [AB-1:0]         done_addr;

  logic                  res_valid_q;
  logic [DATA_W-1:0]     res_addr_q;
  status_e               res_status_q;

  assign busy_o = (state_q != S_IDLE);
  assign accept = start_i && !busy_o;

  fsca_ram #(
    .WIDTH (2 * AB),
    .DEPTH (FREE_ENTRIES)
  ) u_free_ram (
    .clk_i   (clk_i),
    .we_i    (fr_we),
    .waddr_i (fr_waddr),
    .wdata_i (fr_wdata),
    .raddr_i (scan_q[FW-1:0]),
    .rdata_o (fr_rd)
  );

  fsca_ram #(
    .WIDTH (2 * AB),
    .DEPTH (USED_ENTRIES)
  ) u_used_ram (
    .clk_i   (clk_i),
    .we_i    (ur_we),
    .waddr_i (ur_waddr),
    .wdata_i (ur_wdata),
    .raddr_i (scan_q[UW-1:0]),
    .rdata_o (ur_rd)
  );

  fsca_addsub #(
    .WIDTH (AB)
  ) u_addsub (
    .a_i   (alu_a),
    .b_i   (alu_b),
    .sub_i (alu_sub),
    .sum_o (alu_sum),
    .co_o  (alu_co)
  );

  // Check stage of the sweep: the entry whose read data is on the RAM outputs now.
  assign chk_free    = chk_q && (chk_idx_q < CW'(FREE_ENTRIES));
  assign chk_used    = chk_q && (chk_idx_q < CW'(USED_ENTRIES));
  assign fidx        = chk_idx_q[FW-1:0];
  assign uidx        = chk_idx_q[UW-1:0];
  assign f_ent_valid = chk_free && free_valid_q[fidx];
  assign u_ent_valid = chk_used && used_valid_q[uidx];

  // Candidate selection; in the sweep the adder compares sizes.
  always_comb begin
    if (strategy_q == STRAT_WORST) begin
      // adder holds pick size minus entry size: no carry means the entry is larger
      take_pick = f_ent_valid && (!pick_found_q || !alu_co);
    end else if (strategy_q == STRAT_BEST) begin
      take_pick = f_ent_valid && alu_co && (!pick_found_q || (fr_rd.size < pick_q.size));
    end else begin
      take_pick = f_ent_valid && alu_co && !pick_found_q;
    end
  end

  // Next state
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      S_IDLE: begin
        if (start_i) state_d = S_SCAN;
      end
      S_SCAN: begin
        if ((scan_q == CW'(MAXE)) && !chk_q) begin
          state_d = action_q ? S_F_UPDATE : S_A_DECIDE;
        end
      end
      S_A_DECIDE: begin
        if (!uemp_found_q) begin
          state_d = S_IDLE;
        end else if (pick_found_q && alu_co) begin
          state_d = S_A_SPLIT;
        end else begin
          state_d = S_A_HEAP1;
        end
      end
      S_A_SPLIT:  state_d = S_IDLE;
      S_A_HEAP1:  state_d = S_A_HEAP2;
      S_A_HEAP2: begin
        state_d = (top_ok_q && alu_co) ? S_A_HEAP3 : S_IDLE;
      end
      S_A_HEAP3:  state_d = S_IDLE;
      S_F_UPDATE: state_d = S_IDLE;
      default:    state_d = S_IDLE;
    endcase
  end

  // Per-state controls: adder operands, table writes, result
  always_comb begin
    alu_a       = '0;
    alu_b       = '0;
    alu_sub     = 1'b1;
    fr_we       = 1'b0;
    fr_waddr    = pick_idx_q;
    fr_wdata    = hit_q;
    ur_we       = 1'b0;
    ur_waddr    = uemp_idx_q;
    ur_wdata    = '{start: heap_top_q, size: req_q};
    fv_set      = 1'b0;
    fv_clr      = 1'b0;
    fv_idx      = pick_idx_q;
    uv_set      = 1'b0;
    uv_clr      = 1'b0;
    uv_idx      = uemp_idx_q;
    heap_we     = 1'b0;
    done        = 1'b0;
    done_status = ST_OK;
    done_addr   = '0;
    unique case (state_q)
      S_IDLE: ;
      S_SCAN: begin
        if (strategy_q == STRAT_WORST) begin
          alu_a = pick_q.size;
          alu_b = fr_rd.size;
        end else begin
          alu_a = fr_rd.size;
          alu_b = req_q;
        end
      end
      S_A_DECIDE: begin
        alu_a = pick_q.size;
        alu_b = req_q;
        if (!uemp_found_q) begin
          done        = 1'b1;
          done_status = ST_FULL;
        end
      end
      S_A_SPLIT: begin
        // cut the request from the front; an exact fit empties the slot
        alu_a   = pick_q.start;
        alu_b   = req_q;
        alu_sub = 1'b0;
        if (rem_q != '0) begin
          fr_we    = 1'b1;
          fr_waddr = pick_idx_q;
          fr_wdata = '{start: alu_sum, size: rem_q};
        end else begin
          fv_clr = 1'b1;
          fv_idx = pick_idx_q;
        end
        ur_we     = 1'b1;
        ur_wdata  = '{start: pick_q.start, size: req_q};
        uv_set    = 1'b1;
        done      = 1'b1;
        done_addr = pick_q.start;
      end
      S_A_HEAP1: begin
        alu_a = heap_limit_q;
        alu_b = heap_top_q;
      end
      S_A_HEAP2: begin
        alu_a = room_q;
        alu_b = req_q;
        if (!(top_ok_q && alu_co)) begin
          done        = 1'b1;
          done_status = ST_NOHEAP;
        end
      end
      S_A_HEAP3: begin
        alu_a     = heap_top_q;
        alu_b     = req_q;
        alu_sub   = 1'b0;
        heap_we   = 1'b1;
        ur_we     = 1'b1;
        uv_set    = 1'b1;
        done      = 1'b1;
        done_addr = heap_top_q;
      end
      S_F_UPDATE: begin
        done   = 1'b1;
        uv_idx = hit_idx_q;
        if (!hit_found_q) begin
          done_status = ST_UNKNOWN;
        end else if (hit_q.size == '0) begin
          // zero-size chunk: drop it without a free entry
          uv_clr = 1'b1;
        end else if (!femp_found_q) begin
          done_status = ST_FULL;
        end else begin
          fr_we    = 1'b1;
          fr_waddr = femp_idx_q;
          fr_wdata = hit_q;
          fv_set   = 1'b1;
          fv_idx   = femp_idx_q;
          uv_clr   = 1'b1;
        end
      end
      default: ;
    endcase
  end

  // Control state, configuration, valid bits
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= S_IDLE;
      strategy_q   <= STRAT_FIRST;
      heap_top_q   <= '0;
      heap_limit_q <= AB'(32'hFFFF_FFFF);
      free_valid_q <= '0;
      used_valid_q <= '0;
      scan_q       <= '0;
      chk_q        <= 1'b0;
      chk_idx_q    <= '0;
      pick_found_q <= 1'b0;
      uemp_found_q <= 1'b0;
      femp_found_q <= 1'b0;
      hit_found_q  <= 1'b0;
      res_valid_q  <= 1'b0;
    end else begin
      state_q     <= state_d;
      res_valid_q <= done;

      if (cfg_we_i) begin
        unique case (cfg_idx_e'(cfg_idx_i))
          CFG_STRATEGY:   strategy_q   <= cfg_wdata_i[1:0];
          CFG_HEAP_START: heap_top_q   <= AB'(cfg_wdata_i);
          CFG_HEAP_LIMIT: heap_limit_q <= AB'(cfg_wdata_i);
          default: ;
        endcase
      end
      if (heap_we) heap_top_q <= alu_sum;

      if (fv_set) free_valid_q[fv_idx] <= 1'b1;
      if (fv_clr) free_valid_q[fv_idx] <= 1'b0;
      if (uv_set) used_valid_q[uv_idx] <= 1'b1;
      if (uv_clr) used_valid_q[uv_idx] <= 1'b0;

      if (accept) begin
        scan_q       <= '0;
        chk_q        <= 1'b0;
        pick_found_q <= 1'b0;
        uemp_found_q <= 1'b0;
        femp_found_q <= 1'b0;
        hit_found_q  <= 1'b0;
      end else if (state_q == S_SCAN) begin
        // advance the sweep until every slot has been issued
        if (scan_q != CW'(MAXE)) begin
          scan_q    <= scan_q + CW'(1);
          chk_q     <= 1'b1;
          chk_idx_q <= scan_q;
        end else begin
          chk_q <= 1'b0;
        end
        if (!action_q) begin
          if (take_pick) pick_found_q <= 1'b1;
          if (chk_used && !used_valid_q[uidx]) uemp_found_q <= 1'b1;
        end else begin
          if (chk_free && !free_valid_q[fidx]) femp_found_q <= 1'b1;
          if (u_ent_valid && (ur_rd.start == target_q)) hit_found_q <= 1'b1;
        end
      end
    end
  end

  // Payload registers
  always_ff @(posedge clk_i) begin
    if (accept) begin
      action_q <= action_i;
      req_q    <= AB'(request_size_i);
      target_q <= AB'(block_address_i);
    end
    if ((state_q == S_SCAN) && !action_q) begin
      if (take_pick) begin
        pick_idx_q <= fidx;
        pick_q     <= fr_rd;
      end
      if (chk_used && !used_valid_q[uidx] && !uemp_found_q) uemp_idx_q <= uidx;
    end
    if ((state_q == S_SCAN) && action_q) begin
      if (chk_free && !free_valid_q[fidx] && !femp_found_q) femp_idx_q <= fidx;
      if (u_ent_valid && (ur_rd.start == target_q) && !hit_found_q) begin
        hit_idx_q <= uidx;
        hit_q     <= ur_rd;
      end
    end
    if (state_q == S_A_DECIDE) rem_q <= alu_sum;
    if (state_q == S_A_HEAP1) begin
      room_q   <= alu_sum;
      top_ok_q <= alu_co;
    end
    if (done) begin
      res_addr_q   <= DATA_W'(done_addr);
      res_status_q <= done_status;
    end
  end

  assign result_valid_o   = res_valid_q;
  assign result_address_o = res_addr_q;
  assign status_o         = res_status_q;

endmodule

FILE: rtl/fsca_checker.sv
// Port-level checks for the chunk allocator, bound to the top level.
module fsca_checker (
  input logic                           clk_i,
  input logic                           rst_ni,
  input logic                           start_i,
  input logic                           busy_o,
  input logic                           result_valid_o,
  input logic [fsca_pkg::DATA_W-1:0]    result_address_o,
  input logic [fsca_pkg::STATUS_W-1:0]  status_o
);

  import fsca_pkg::*;

  a_accept_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (start_i && !busy_o) |=> busy_o)
    else $error("accepted request did not raise busy");

  a_single_strobe: assert property (@(posedge clk_i) disable iff (!rst_ni)
    result_valid_o |=> !result_valid_o)
    else $error("result strobe longer than one cycle");

  a_done_has_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $fell(busy_o) |-> result_valid_o)
    else $error("request finished without a result");

  a_strobe_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    result_valid_o |-> !busy_o)
    else $error("result strobe while still busy");

  a_error_zero_addr: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (result_valid_o && (status_o != ST_OK)) |-> (result_address_o == '0))
    else $error("error result with nonzero address");

endmodule

bind fit_strategy_chunk_allocator fsca_checker u_fsca_checker (
  .clk_i            (clk_i),
  .rst_ni           (rst_ni),
  .start_i          (start_i),
  .busy_o           (busy_o),
  .result_valid_o   (result_valid_o),
  .result_address_o (result_address_o),
  .status_o         (status_o)
);
